>>> design/yuv_pixel_blend_modes_macros.svh
// Assertion macros shared by the blend block
`ifndef YUV_PIXEL_BLEND_MODES_MACROS_SVH
`define YUV_PIXEL_BLEND_MODES_MACROS_SVH

// Check that a condition implies another in the same cycle
`define YPB_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition is followed by another a fixed number of cycles later
`define YPB_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

>>> design/yuvb_pkg.sv
// Shared types, constants and helper functions of the pixel blend block
package yuvb_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int MODE_W     = 5;
   localparam int NUM_W      = 2 * SAMPLE_W;
   localparam int DEN_W      = SAMPLE_W;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = NUM_W / DIV_STEPS;

   localparam logic [SAMPLE_W-1:0] LO_CLAMP   = 8'd16;
   localparam logic [SAMPLE_W-1:0] HI_CLAMP   = 8'd240;
   localparam logic [SAMPLE_W-1:0] HI_VIDEO   = 8'd235;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'd255;
   localparam logic [NUM_W-1:0]    FREEZE_MAX = 16'd239;

   localparam logic signed [11:0] S_FULL = 12'sd255;
   localparam logic signed [11:0] S_HI   = 12'sd240;
   localparam logic signed [11:0] S_MID  = 12'sd128;

   typedef enum logic [MODE_W-1:0] {
      M_ADDITIVE    = 5'd0,
      M_SUBTRACT    = 5'd1,
      M_MULTIPLY    = 5'd2,
      M_DIVIDE      = 5'd3,
      M_LIGHTEN     = 5'd4,
      M_DIFFERENCE  = 5'd5,
      M_DIFFNEG     = 5'd6,
      M_EXCLUSION   = 5'd7,
      M_BASECOLOR   = 5'd8,
      M_FREEZE      = 5'd9,
      M_UNFREEZE    = 5'd10,
      M_RELADD      = 5'd11,
      M_RELSUB      = 5'd12,
      M_RELADDLUM   = 5'd13,
      M_RELSUBLUM   = 5'd14,
      M_MAXSEL      = 5'd15,
      M_MINSEL      = 5'd16,
      M_MINSUBSEL   = 5'd17,
      M_MAXSUBSEL   = 5'd18,
      M_ADDSUBSEL   = 5'd19,
      M_ADDAVG      = 5'd20,
      M_ADDTEST     = 5'd21,
      M_ADDTEST3    = 5'd22,
      M_ADDTEST4    = 5'd23,
      M_MULSUB      = 5'd24,
      M_SOFTBURN    = 5'd25,
      M_INVBURN     = 5'd26,
      M_COLORDODGE  = 5'd27,
      M_ADDDISTORT  = 5'd28,
      M_SUBDISTORT  = 5'd29,
      M_TRY         = 5'd30
   } mode_type;

   // Side data that rides along the first divider
   typedef struct packed {
      logic                chroma;
      mode_type            mode;
      logic                use_div;
      logic [SAMPLE_W-1:0] a;
      logic [SAMPLE_W-1:0] simple;
   } side_type;

   // Side data that rides along the last divider
   typedef struct packed {
      logic                is_try;
      logic                early;
      logic [SAMPLE_W-1:0] result;
   } final_side_type;

   // Partial remainder and dividend/quotient shift word
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] num;
   } div_state_type;

   // One restoring division step: shift in a dividend bit, subtract if it fits
   function automatic div_state_type div_step(div_state_type s, logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      div_state_type  r;
      trial = {s.rem, s.num[NUM_W-1]};
      diff  = trial - {1'b0, den};
      r.num = {s.num[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         r.rem    = diff[DEN_W-1:0];
         r.num[0] = 1'b1;
      end else begin
         r.rem = trial[DEN_W-1:0];
      end
      return r;
   endfunction

   // Clamp a signed intermediate into lo..hi
   function automatic logic [SAMPLE_W-1:0] clamp(logic signed [11:0] v,
                                                 logic [SAMPLE_W-1:0] lo,
                                                 logic [SAMPLE_W-1:0] hi);
      logic [SAMPLE_W-1:0] r;
      if (v < $signed({4'd0, lo})) begin
         r = lo;
      end else if (v > $signed({4'd0, hi})) begin
         r = hi;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> design/yuvb_div.sv
// Pipelined restoring divider, two quotient bits per stage, with side data
module yuvb_div #(
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [yuvb_pkg::NUM_W-1:0]    in_num,
   input  logic [yuvb_pkg::DEN_W-1:0]    in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [yuvb_pkg::NUM_W-1:0]    out_quo,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int STAGES = yuvb_pkg::DIV_STAGES;

   logic                        valid_ff [STAGES];
   yuvb_pkg::div_state_type     state_ff [STAGES];
   logic [yuvb_pkg::DEN_W-1:0]  den_ff   [STAGES];
   logic [SIDE_W-1:0]           side_ff  [STAGES];

   genvar s;
   generate
      for (s = 0; s < STAGES; s++) begin : g_stage
         logic                        src_valid;
         yuvb_pkg::div_state_type     src_state;
         logic [yuvb_pkg::DEN_W-1:0]  src_den;
         logic [SIDE_W-1:0]           src_side;
         yuvb_pkg::div_state_type     state_in;

         // Pick the stage source: ports for the first stage, else the stage before
         if (s == 0) begin : g_first
            assign src_valid     = in_valid;
            assign src_state.rem = '0;
            assign src_state.num = in_num;
            assign src_den       = in_den;
            assign src_side      = in_side;
         end else begin : g_next
            assign src_valid = valid_ff[s-1];
            assign src_state = state_ff[s-1];
            assign src_den   = den_ff[s-1];
            assign src_side  = side_ff[s-1];
         end

         // Run the division steps of this stage
         always_comb begin
            state_in = src_state;
            for (int i = 0; i < yuvb_pkg::DIV_STEPS; i++) begin
               state_in = yuvb_pkg::div_step(state_in, src_den);
            end
         end

         // Advance the valid bit
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else begin
               valid_ff[s] <= src_valid;
            end
         end

         // Advance the payload
         always_ff @(posedge clock) begin
            state_ff[s] <= state_in;
            den_ff[s]   <= src_den;
            side_ff[s]  <= src_side;
         end
      end
   endgenerate

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo   = state_ff[STAGES-1].num;
   assign out_side  = side_ff[STAGES-1];

endmodule

>>> design/yuvb_front.sv
// Front stages: input register, products, direct-mode results and divider operands
module yuvb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [yuvb_pkg::SAMPLE_W-1:0] in_a,
   input  logic [yuvb_pkg::SAMPLE_W-1:0] in_b,
   input  logic                         in_chroma,
   input  yuvb_pkg::mode_type           in_mode,
   output logic                         out_valid,
   output logic [yuvb_pkg::NUM_W-1:0]   out_num1,
   output logic [yuvb_pkg::DEN_W-1:0]   out_den1,
   output logic [yuvb_pkg::NUM_W-1:0]   out_num2,
   output logic [yuvb_pkg::DEN_W-1:0]   out_den2,
   output yuvb_pkg::side_type           out_side
);

   // Stage 1 registers
   logic                          s1_valid_ff;
   logic [yuvb_pkg::SAMPLE_W-1:0] s1_a_ff, s1_b_ff;
   logic                          s1_chroma_ff;
   yuvb_pkg::mode_type            s1_mode_ff;

   // Stage 2 registers
   logic                          s2_valid_ff;
   logic [yuvb_pkg::SAMPLE_W-1:0] s2_a_ff, s2_b_ff;
   logic                          s2_chroma_ff;
   yuvb_pkg::mode_type            s2_mode_ff;
   logic [yuvb_pkg::NUM_W-1:0]    s2_sq1_ff, s2_sq2_ff, s2_p8_ff;
   logic signed [17:0]            s2_ps_ff;

   // Stage 3 registers
   logic                          s3_valid_ff;
   logic [yuvb_pkg::NUM_W-1:0]    s3_num1_ff, s3_num2_ff;
   logic [yuvb_pkg::DEN_W-1:0]    s3_den1_ff, s3_den2_ff;
   yuvb_pkg::side_type            s3_side_ff;

   // Stage 2 combinational
   logic [yuvb_pkg::SAMPLE_W-1:0] b_a16, b_b16, sq1_op, b_na, nb, b_na16, b_nb16;
   logic signed [8:0]             ps_x, ps_y;
   logic [yuvb_pkg::NUM_W-1:0]    sq1_in, sq2_in, p8_in;
   logic signed [17:0]            ps_in;

   // Stage 3 combinational
   logic signed [11:0]            sa, sb, diff, absd, t6, abs6, rsub, rsub_rev, d8, k8, excl_c;
   logic [yuvb_pkg::SAMPLE_W-1:0] a16, b16, half_sum, c19, d19, term8, base8, prod_hi, simple_in;
   logic [yuvb_pkg::SAMPLE_W-1:0] rsub8, rsub_rev8, den1_in, max_ab, min_ab;
   logic [8:0]                    c8, pp, sum19;
   logic signed [17:0]            ps_sh;
   logic                          use_div_in;

   // Register the request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_a_ff      <= in_a;
      s1_b_ff      <= in_b;
      s1_chroma_ff <= in_chroma;
      s1_mode_ff   <= in_mode;
   end

   // Select multiplier operands
   always_comb begin
      b_a16  = (s1_a_ff < yuvb_pkg::LO_CLAMP) ? yuvb_pkg::LO_CLAMP : s1_a_ff;
      b_b16  = (s1_b_ff < yuvb_pkg::LO_CLAMP) ? yuvb_pkg::LO_CLAMP : s1_b_ff;
      b_na   = ~s1_a_ff;
      nb     = ~s1_b_ff;
      b_na16 = ~b_a16;
      b_nb16 = ~b_b16;
      unique case (s1_mode_ff)
         yuvb_pkg::M_FREEZE:   sq1_op = b_na;
         yuvb_pkg::M_UNFREEZE: sq1_op = nb;
         yuvb_pkg::M_ADDTEST4: sq1_op = b_a16;
         yuvb_pkg::M_TRY:      sq1_op = b_na;
         default:              sq1_op = s1_a_ff;
      endcase
      if (s1_chroma_ff && (s1_mode_ff == yuvb_pkg::M_EXCLUSION)) begin
         ps_x = $signed({1'b0, s1_a_ff} - 9'd128);
         ps_y = $signed({1'b0, s1_b_ff} - 9'd128);
      end else if (s1_mode_ff == yuvb_pkg::M_BASECOLOR) begin
         ps_x = $signed({1'b0, b_a16});
         ps_y = $signed({1'b0, b_b16});
      end else begin
         ps_x = $signed({1'b0, s1_a_ff});
         ps_y = $signed({1'b0, s1_b_ff});
      end
      sq1_in = {8'd0, sq1_op} * {8'd0, sq1_op};
      sq2_in = {8'd0, nb} * {8'd0, nb};
      p8_in  = {8'd0, b_na16} * {8'd0, b_nb16};
      ps_in  = ps_x * ps_y;
   end

   // Register the products
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_a_ff      <= s1_a_ff;
      s2_b_ff      <= s1_b_ff;
      s2_chroma_ff <= s1_chroma_ff;
      s2_mode_ff   <= s1_mode_ff;
      s2_sq1_ff    <= sq1_in;
      s2_sq2_ff    <= sq2_in;
      s2_p8_ff     <= p8_in;
      s2_ps_ff     <= ps_in;
   end

   // Form the direct-mode result and the divisor
   always_comb begin
      sa        = $signed({4'd0, s2_a_ff});
      sb        = $signed({4'd0, s2_b_ff});
      a16       = (s2_a_ff < yuvb_pkg::LO_CLAMP) ? yuvb_pkg::LO_CLAMP : s2_a_ff;
      b16       = (s2_b_ff < yuvb_pkg::LO_CLAMP) ? yuvb_pkg::LO_CLAMP : s2_b_ff;
      max_ab    = (s2_b_ff > s2_a_ff) ? s2_b_ff : s2_a_ff;
      min_ab    = (s2_b_ff < s2_a_ff) ? s2_b_ff : s2_a_ff;
      diff      = sa - sb;
      absd      = (diff < 0) ? -diff : diff;
      t6        = yuvb_pkg::S_FULL - sa - sb;
      abs6      = (t6 < 0) ? -t6 : t6;
      half_sum  = {1'b0, s2_a_ff[7:1]} + {1'b0, s2_b_ff[7:1]};
      rsub      = (sa - sb + yuvb_pkg::S_FULL) >>> 1;
      rsub_rev  = (sb - sa + yuvb_pkg::S_FULL) >>> 1;
      rsub8     = rsub[7:0];
      rsub_rev8 = rsub_rev[7:0];
      c19       = yuvb_pkg::clamp(sa, yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_CLAMP);
      d19       = yuvb_pkg::clamp(sb, yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_CLAMP);
      sum19     = {1'b0, c19} + {1'b0, d19};
      prod_hi   = s2_ps_ff[15:8];

      // Base color: scale term is a small signed multiple of the base
      c8 = s2_ps_ff[15:7];
      pp = s2_p8_ff[15:7];
      d8 = yuvb_pkg::S_FULL - $signed({3'd0, pp}) - $signed({3'd0, c8});
      k8 = d8 >>> 7;
      if (k8 == 12'sd1) begin
         term8 = a16;
      end else if (k8 == -12'sd1) begin
         term8 = 8'd0 - a16;
      end else if (k8 == -12'sd2) begin
         term8 = 8'd0 - {a16[6:0], 1'b0};
      end else begin
         term8 = 8'd0;
      end
      base8 = c8[7:0] + term8;

      // Chroma exclusion on centered samples
      ps_sh  = s2_ps_ff >>> 8;
      excl_c = sa + sb - yuvb_pkg::S_MID - $signed(ps_sh[11:0]);

      use_div_in = 1'b0;
      simple_in  = s2_a_ff;
      if (s2_chroma_ff) begin
         unique case (s2_mode_ff)
            yuvb_pkg::M_EXCLUSION:
               simple_in = yuvb_pkg::clamp(excl_c, yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_VIDEO);
            yuvb_pkg::M_RELADD:     simple_in = half_sum;
            yuvb_pkg::M_RELSUB:     simple_in = rsub8;
            yuvb_pkg::M_ADDAVG:     simple_in = s2_a_ff + s2_b_ff;
            yuvb_pkg::M_ADDTEST3:
               simple_in = yuvb_pkg::clamp(sa + sb + sb - yuvb_pkg::S_FULL,
                                           yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_CLAMP);
            yuvb_pkg::M_ADDDISTORT:
               simple_in = yuvb_pkg::clamp(sa + sb, yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_VIDEO);
            yuvb_pkg::M_SUBDISTORT: simple_in = s2_a_ff - s2_b_ff;
            default:                simple_in = s2_a_ff;
         endcase
      end else begin
         unique case (s2_mode_ff)
            yuvb_pkg::M_ADDITIVE:
               simple_in = yuvb_pkg::clamp(sa + sb + sb - yuvb_pkg::S_FULL,
                                           yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_CLAMP);
            yuvb_pkg::M_SUBTRACT:
               simple_in = yuvb_pkg::clamp(sa + sb - yuvb_pkg::S_HI,
                                           yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_CLAMP);
            yuvb_pkg::M_MULTIPLY:   simple_in = prod_hi;
            yuvb_pkg::M_DIVIDE,
            yuvb_pkg::M_FREEZE,
            yuvb_pkg::M_UNFREEZE,
            yuvb_pkg::M_ADDTEST4,
            yuvb_pkg::M_TRY:        use_div_in = 1'b1;
            yuvb_pkg::M_LIGHTEN:
               simple_in = yuvb_pkg::clamp($signed({4'd0, max_ab}),
                                           yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_CLAMP);
            yuvb_pkg::M_DIFFERENCE: simple_in = absd[7:0];
            yuvb_pkg::M_DIFFNEG:    simple_in = yuvb_pkg::FULL_SCALE - abs6[7:0];
            yuvb_pkg::M_EXCLUSION:
               simple_in = yuvb_pkg::clamp(sa + sb - $signed({4'd0, prod_hi}),
                                           yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_CLAMP);
            yuvb_pkg::M_BASECOLOR:  simple_in = base8;
            yuvb_pkg::M_RELADD:     simple_in = half_sum;
            yuvb_pkg::M_RELSUB,
            yuvb_pkg::M_RELSUBLUM:  simple_in = rsub8;
            yuvb_pkg::M_RELADDLUM:
               simple_in = (half_sum < s2_a_ff) ? s2_a_ff : half_sum;
            yuvb_pkg::M_MAXSEL:     simple_in = max_ab;
            yuvb_pkg::M_MINSEL:     simple_in = min_ab;
            yuvb_pkg::M_MINSUBSEL:
               simple_in = (s2_b_ff < s2_a_ff) ? rsub_rev8 : rsub8;
            yuvb_pkg::M_MAXSUBSEL:
               simple_in = (s2_b_ff > s2_a_ff) ? rsub_rev8 : rsub8;
            yuvb_pkg::M_ADDSUBSEL:
               simple_in = (d19 < c19) ? sum19[8:1] : s2_a_ff;
            yuvb_pkg::M_ADDAVG:     simple_in = s2_a_ff + s2_b_ff;
            yuvb_pkg::M_ADDTEST,
            yuvb_pkg::M_ADDTEST3:
               simple_in = yuvb_pkg::clamp(sa + sb + sb - yuvb_pkg::S_HI,
                                           yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_CLAMP);
            yuvb_pkg::M_MULSUB:     simple_in = yuvb_pkg::LO_CLAMP;
            yuvb_pkg::M_SOFTBURN:
               simple_in = (sa + sb < yuvb_pkg::S_HI) ? 8'd0 : yuvb_pkg::HI_CLAMP;
            yuvb_pkg::M_INVBURN:
               simple_in = (s2_a_ff < yuvb_pkg::LO_CLAMP) ? yuvb_pkg::LO_CLAMP
                                                          : yuvb_pkg::HI_CLAMP;
            yuvb_pkg::M_COLORDODGE:
               simple_in = (s2_a_ff >= yuvb_pkg::HI_CLAMP) ? yuvb_pkg::HI_CLAMP : 8'd0;
            yuvb_pkg::M_ADDDISTORT:
               simple_in = yuvb_pkg::clamp(sa + sb, yuvb_pkg::LO_CLAMP, yuvb_pkg::HI_CLAMP);
            yuvb_pkg::M_SUBDISTORT: simple_in = s2_a_ff - s2_b_ff;
            default:                simple_in = s2_a_ff;
         endcase
      end

      unique case (s2_mode_ff)
         yuvb_pkg::M_DIVIDE:
            den1_in = (s2_b_ff == yuvb_pkg::FULL_SCALE) ? yuvb_pkg::LO_CLAMP : ~s2_b_ff;
         yuvb_pkg::M_FREEZE:   den1_in = s2_b_ff;
         yuvb_pkg::M_UNFREEZE: den1_in = s2_a_ff;
         yuvb_pkg::M_ADDTEST4: den1_in = b16;
         yuvb_pkg::M_TRY:      den1_in = s2_a_ff;
         default:              den1_in = 8'd1;
      endcase
   end

   // Register the divider operands
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_num1_ff          <= s2_sq1_ff;
      s3_den1_ff          <= den1_in;
      s3_num2_ff          <= s2_sq2_ff;
      s3_den2_ff          <= s2_b_ff;
      s3_side_ff.chroma   <= s2_chroma_ff;
      s3_side_ff.mode     <= s2_mode_ff;
      s3_side_ff.use_div  <= use_div_in;
      s3_side_ff.a        <= s2_a_ff;
      s3_side_ff.simple   <= simple_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_num1  = s3_num1_ff;
   assign out_den1  = s3_den1_ff;
   assign out_num2  = s3_num2_ff;
   assign out_den2  = s3_den2_ff;
   assign out_side  = s3_side_ff;

endmodule

>>> design/yuvb_mix.sv
// Middle stages: finish the divide modes and set up the second division
module yuvb_mix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [yuvb_pkg::NUM_W-1:0]    in_q1,
   input  logic [yuvb_pkg::NUM_W-1:0]    in_q2,
   input  yuvb_pkg::side_type            in_side,
   input  logic [yuvb_pkg::SAMPLE_W-1:0] in_b,
   output logic                          out_valid,
   output logic [yuvb_pkg::NUM_W-1:0]    out_num,
   output logic [yuvb_pkg::DEN_W-1:0]    out_den,
   output yuvb_pkg::final_side_type      out_side
);

   // Stage E registers
   logic                          e_valid_ff;
   logic [yuvb_pkg::SAMPLE_W-1:0] e_p_ff, e_qv_ff, e_b_ff;
   yuvb_pkg::final_side_type      e_side_ff;

   // Stage F registers
   logic                          f_valid_ff;
   logic [yuvb_pkg::NUM_W-1:0]    f_num_ff;
   logic [yuvb_pkg::DEN_W-1:0]    f_den_ff;
   yuvb_pkg::final_side_type      f_side_ff;

   logic                          a_lt16, b_lt16, q1_big, q2_big;
   logic [yuvb_pkg::SAMPLE_W-1:0] q1_lo, q2_lo, a_cap, div_res, p_in, qv_in;
   logic [yuvb_pkg::NUM_W-1:0]    num_in;
   yuvb_pkg::final_side_type      side_in;

   // Resolve the divide modes
   always_comb begin
      a_lt16 = in_side.a < yuvb_pkg::LO_CLAMP;
      b_lt16 = in_b < yuvb_pkg::LO_CLAMP;
      q1_big = in_q1 > yuvb_pkg::FREEZE_MAX;
      q2_big = in_q2 > yuvb_pkg::FREEZE_MAX;
      q1_lo  = yuvb_pkg::FULL_SCALE - in_q1[7:0];
      q2_lo  = yuvb_pkg::FULL_SCALE - in_q2[7:0];
      a_cap  = (in_side.a > yuvb_pkg::HI_VIDEO) ? yuvb_pkg::HI_VIDEO : in_side.a;

      unique case (in_side.mode)
         yuvb_pkg::M_DIVIDE: begin
            if (in_q1 < {8'd0, yuvb_pkg::LO_CLAMP}) begin
               div_res = yuvb_pkg::LO_CLAMP;
            end else if (in_q1 > {8'd0, yuvb_pkg::HI_VIDEO}) begin
               div_res = yuvb_pkg::HI_VIDEO;
            end else begin
               div_res = in_q1[7:0];
            end
         end
         yuvb_pkg::M_FREEZE: begin
            if (b_lt16) begin
               div_res = a_lt16 ? in_b : a_cap;
            end else if (q1_big) begin
               div_res = in_b;
            end else begin
               div_res = (q1_lo > yuvb_pkg::HI_VIDEO) ? yuvb_pkg::HI_VIDEO : q1_lo;
            end
         end
         yuvb_pkg::M_UNFREEZE:
            div_res = (a_lt16 || q1_big) ? yuvb_pkg::LO_CLAMP : q1_lo;
         yuvb_pkg::M_ADDTEST4: begin
            if (in_q1 < {8'd0, yuvb_pkg::LO_CLAMP}) begin
               div_res = yuvb_pkg::LO_CLAMP;
            end else if (in_q1 > {8'd0, yuvb_pkg::HI_CLAMP}) begin
               div_res = yuvb_pkg::HI_CLAMP;
            end else begin
               div_res = in_q1[7:0];
            end
         end
         default: div_res = in_side.simple;
      endcase

      // Try mode: both freeze-like terms, each floored at 16
      p_in  = (a_lt16 || q1_big) ? yuvb_pkg::LO_CLAMP : q1_lo;
      qv_in = (b_lt16 || q2_big) ? yuvb_pkg::LO_CLAMP : q2_lo;

      side_in.is_try = in_side.use_div && (in_side.mode == yuvb_pkg::M_TRY);
      side_in.early  = !b_lt16 && q2_big;
      side_in.result = in_side.use_div ? div_res : in_side.simple;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= in_valid;
         f_valid_ff <= e_valid_ff;
      end
   end

   // Hold the try terms, then form the second dividend
   always_comb begin
      num_in = {8'd0, ~e_p_ff} * {8'd0, ~e_b_ff};
   end

   always_ff @(posedge clock) begin
      e_p_ff    <= p_in;
      e_qv_ff   <= qv_in;
      e_b_ff    <= in_b;
      e_side_ff <= side_in;
      f_num_ff  <= num_in;
      f_den_ff  <= e_qv_ff;
      f_side_ff <= e_side_ff;
   end

   assign out_valid = f_valid_ff;
   assign out_num   = f_num_ff;
   assign out_den   = f_den_ff;
   assign out_side  = f_side_ff;

endmodule

>>> design/yuv_pixel_blend_modes.sv
// Top level of the per-sample two-frame blend block
//
//   channel   ports                                 handshake
//   request   req_base_sample req_overlay_sample    start, taken when busy is low
//             req_is_chroma
//   result    rsp_blended_sample                    rsp_valid strobe, one cycle
//   config    csr_blend_mode                        csr_valid / csr_ready
//
// One request per clock while busy is low; a result passes the front stages,
// two parallel 8-stage dividers, the mix stages, a third divider and a register.
// busy is high only during reset; the result strobe has no back-pressure.
// Reset clears the pipeline valid bits and sets the blend mode to 0.
module yuv_pixel_blend_modes (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [yuvb_pkg::SAMPLE_W-1:0] req_base_sample,
   input  logic [yuvb_pkg::SAMPLE_W-1:0] req_overlay_sample,
   input  logic                          req_is_chroma,
   output logic                          rsp_valid,
   output logic [yuvb_pkg::SAMPLE_W-1:0] rsp_blended_sample,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [yuvb_pkg::MODE_W-1:0]   csr_blend_mode
);

   localparam int LATENCY = 2 * yuvb_pkg::DIV_STAGES + 6;

   yuvb_pkg::mode_type            mode_ff;
   logic                          req_take;

   logic                          fr_valid;
   logic [yuvb_pkg::NUM_W-1:0]    fr_num1, fr_num2;
   logic [yuvb_pkg::DEN_W-1:0]    fr_den1, fr_den2;
   yuvb_pkg::side_type            fr_side;

   logic                          d1_valid, d2_valid;
   logic [yuvb_pkg::NUM_W-1:0]    d1_quo, d2_quo;
   yuvb_pkg::side_type            d1_side;
   logic [yuvb_pkg::SAMPLE_W-1:0] d2_b;

   logic                          mx_valid;
   logic [yuvb_pkg::NUM_W-1:0]    mx_num;
   logic [yuvb_pkg::DEN_W-1:0]    mx_den;
   yuvb_pkg::final_side_type      mx_side;

   logic                          d3_valid;
   logic [yuvb_pkg::NUM_W-1:0]    d3_quo;
   yuvb_pkg::final_side_type      d3_side;

   logic                          rsp_valid_ff;
   logic [yuvb_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign req_take  = start && !busy;

   // Hold the blend mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= yuvb_pkg::M_ADDITIVE;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= yuvb_pkg::mode_type'(csr_blend_mode);
      end
   end

   yuvb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_a      (req_base_sample),
      .in_b      (req_overlay_sample),
      .in_chroma (req_is_chroma),
      .in_mode   (mode_ff),
      .out_valid (fr_valid),
      .out_num1  (fr_num1),
      .out_den1  (fr_den1),
      .out_num2  (fr_num2),
      .out_den2  (fr_den2),
      .out_side  (fr_side)
   );

   yuvb_div #(.SIDE_W($bits(yuvb_pkg::side_type))) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_num    (fr_num1),
      .in_den    (fr_den1),
      .in_side   (fr_side),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   // Second lane divides by the overlay sample, so it carries that sample along
   yuvb_div #(.SIDE_W(yuvb_pkg::SAMPLE_W)) u_div2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_num    (fr_num2),
      .in_den    (fr_den2),
      .in_side   (fr_den2),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_b)
   );

   yuvb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid && d2_valid),
      .in_q1     (d1_quo),
      .in_q2     (d2_quo),
      .in_side   (d1_side),
      .in_b      (d2_b),
      .out_valid (mx_valid),
      .out_num   (mx_num),
      .out_den   (mx_den),
      .out_side  (mx_side)
   );

   yuvb_div #(.SIDE_W($bits(yuvb_pkg::final_side_type))) u_div3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mx_valid),
      .in_num    (mx_num),
      .in_den    (mx_den),
      .in_side   (mx_side),
      .out_valid (d3_valid),
      .out_quo   (d3_quo),
      .out_side  (d3_side)
   );

   // Pick the try result or the earlier one
   always_comb begin
      if (d3_side.is_try) begin
         rsp_sample_in = (d3_side.early || (d3_quo > yuvb_pkg::FREEZE_MAX))
                         ? yuvb_pkg::LO_CLAMP
                         : yuvb_pkg::FULL_SCALE - d3_quo[7:0];
      end else begin
         rsp_sample_in = d3_side.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_blended_sample = rsp_sample_ff;

`include "yuv_pixel_blend_modes_macros.svh"

   `YPB_ASSERT_DELAY(a_req_gives_rsp, req_take, LATENCY, rsp_valid, "request lost in pipeline")
   `YPB_ASSERT_IMPL(a_rsp_has_req, rsp_valid, $past(req_take, LATENCY), "result without request")
   `YPB_ASSERT_IMPL(a_lanes_aligned, d1_valid || d2_valid, d1_valid && d2_valid, "divider lanes skewed")

endmodule
